// ----- rtl/binary_heap_priority_queue_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Binary heap priority queue assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define BHPQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bhpq: same-cycle check failed");

`define BHPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bhpq: next-cycle check failed");

`else

`define BHPQ_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define BHPQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/bhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bhpq_pkg
// Types, codes and helpers shared by the binary heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int DEPTH        = 64;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int IDX_W        = ADDR_W + 2;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] RD_NONE   = 2'd0;
  localparam logic [1:0] RD_ROOT   = 2'd1;
  localparam logic [1:0] RD_PARENT = 2'd2;
  localparam logic [1:0] RD_CHILD  = 2'd3;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_HOLD = 2'd1;
  localparam logic [1:0] WR_A    = 2'd2;
  localparam logic [1:0] WR_B    = 2'd3;

  localparam logic [1:0] POS_KEEP   = 2'd0;
  localparam logic [1:0] POS_PARENT = 2'd1;
  localparam logic [1:0] POS_LEFT   = 2'd2;
  localparam logic [1:0] POS_RIGHT  = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [KEY_BITS-1:0]     entry_key;
    logic [PAYLOAD_BITS-1:0] entry_payload;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     head_key;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic [CNT_W-1:0]        entry_count;
  } out_t;

  typedef struct packed {
    logic       accept;
    logic       take_root;
    logic [1:0] rd_sel;
    logic [1:0] wr_sel;
    logic [1:0] pos_sel;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic in_insert;
    logic is_remove;
    logic full;
    logic empty;
    logic count_one;
    logic pos_zero;
    logic left_ok;
    logic up_move;
    logic dn_sel_l;
    logic dn_sel_r;
    logic out_free;
  } sts_t;

  function automatic logic goes_before(input logic [KEY_BITS-1:0] a,
                                       input logic [KEY_BITS-1:0] b,
                                       input logic                lf);
    return lf ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/binary_heap_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// Min/max binary heap priority queue of 64 key and payload entries.
// ----------------------------------------------------------------------------
// One transaction at a time: look reads the root, insert sifts the entry up,
// remove takes the root and sifts the last entry down, and a refused insert or
// a look or remove on an empty queue goes straight to the result, which waits
// for the output to take it. The pace is set by the single heap memory: each
// sift step reads a parent or both children, then compares and writes one
// entry. largest_first selects max-first order; it must be written only while
// idle, which the block itself does not enforce.
// Insert into a full queue returns status full; remove or look on an empty
// queue returns status empty. No clearing pass is needed after reset.
`default_nettype none

`include "binary_heap_priority_queue_unit_assert.svh"

module binary_heap_priority_queue_unit
  import bhpq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  bhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bhpq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  `BHPQ_ASSERT_IMPLY(a_emit_slot_free, clk, rst, cmd.emit, sts.out_free)
  `BHPQ_ASSERT_IMPLY(a_no_write_idle, clk, rst, cmd.wr_sel != WR_NONE, in_stall)
  `BHPQ_ASSERT_IMPLY(a_count_bound, clk, rst, out_valid, out_data.entry_count <= CNT_W'(DEPTH))
  `BHPQ_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, out_valid)

endmodule

`default_nettype wire

// ----- rtl/bhpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for insert, remove and look: sift up, sift down, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ctrl
  import bhpq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROOT   = 3'd1;
  localparam logic [2:0] S_UP_RD  = 3'd2;
  localparam logic [2:0] S_UP_CMP = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.rd_sel = RD_ROOT;
          if (sts.in_insert) begin
            state_next = sts.full ? S_DONE : S_UP_RD;
          end else begin
            state_next = sts.empty ? S_DONE : S_ROOT;
          end
        end
      end
      S_ROOT: begin
        cmd.take_root = 1'b1;
        state_next    = (sts.is_remove && !sts.count_one) ? S_DN_RD : S_DONE;
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.wr_sel = WR_HOLD;
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_move) begin
          cmd.wr_sel  = WR_A;
          cmd.pos_sel = POS_PARENT;
          state_next  = S_UP_RD;
        end else begin
          cmd.wr_sel = WR_HOLD;
          state_next = S_DONE;
        end
      end
      S_DN_RD: begin
        if (!sts.left_ok) begin
          cmd.wr_sel = WR_HOLD;
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_CHILD;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        priority if (sts.dn_sel_r) begin
          cmd.wr_sel  = WR_B;
          cmd.pos_sel = POS_RIGHT;
          state_next  = S_DN_RD;
        end else if (sts.dn_sel_l) begin
          cmd.wr_sel  = WR_A;
          cmd.pos_sel = POS_LEFT;
          state_next  = S_DN_RD;
        end else begin
          cmd.wr_sel = WR_HOLD;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bhpq_datapath.sv -----
// ----------------------------------------------------------------------------
// bhpq_datapath
// Heap memory, working position, held entry, count, order register, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_datapath
  import bhpq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  in_data,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  entry_t mem [DEPTH];

  entry_t           rd_a;
  entry_t           rd_b;
  entry_t           hold;
  entry_t           head;
  entry_t           wr_data;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] parent;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [IDX_W-1:0]  left;
  logic [IDX_W-1:0]  right;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_m1;
  logic [1:0]        mode;
  logic [1:0]        status;
  logic [1:0]        status_next;
  logic              largest_first;
  logic              right_ok;
  logic [KEY_BITS-1:0] best_key;

  assign parent   = (pos - 1'b1) >> 1;
  assign left     = (IDX_W'(pos) << 1) + IDX_W'(1);
  assign right    = (IDX_W'(pos) << 1) + IDX_W'(2);
  assign count_m1 = count - 1'b1;
  assign right_ok = right < IDX_W'(count);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ROOT: begin
        rd_addr_a = '0;
        rd_addr_b = count_m1[ADDR_W-1:0];
      end
      RD_PARENT: begin
        rd_addr_a = parent;
        rd_addr_b = parent;
      end
      RD_CHILD: begin
        rd_addr_a = left[ADDR_W-1:0];
        rd_addr_b = right[ADDR_W-1:0];
      end
      default: begin
        rd_addr_a = pos;
        rd_addr_b = pos;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_A:    wr_data = rd_a;
      WR_B:    wr_data = rd_b;
      default: wr_data = hold;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
    if (cmd.wr_sel != WR_NONE) begin
      mem[pos] <= wr_data;
    end
  end

  always_comb begin
    sts.in_insert = (in_data.mode == MODE_INSERT);
    sts.is_remove = (mode == MODE_REMOVE);
    sts.full      = (count == CNT_W'(DEPTH));
    sts.empty     = (count == '0);
    sts.count_one = (count == CNT_W'(1));
    sts.pos_zero  = (pos == '0);
    sts.left_ok   = left < IDX_W'(count);
    sts.up_move   = goes_before(hold.key, rd_a.key, largest_first);
    sts.dn_sel_l  = sts.left_ok && goes_before(rd_a.key, hold.key, largest_first);
    best_key      = sts.dn_sel_l ? rd_a.key : hold.key;
    sts.dn_sel_r  = right_ok && goes_before(rd_b.key, best_key, largest_first);
    sts.out_free  = !out_valid || !out_stall;
  end

  always_comb begin
    if (sts.in_insert) begin
      status_next = sts.full ? ST_FULL : ST_OK;
    end else begin
      status_next = sts.empty ? ST_EMPTY : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      out_valid     <= 1'b0;
      largest_first <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        largest_first <= cfg_wr_data;
      end
      if (cmd.accept && sts.in_insert && !sts.full) begin
        count <= count + 1'b1;
      end else if (cmd.take_root && sts.is_remove) begin
        count <= count_m1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode   <= in_data.mode;
      status <= status_next;
      head   <= '0;
      hold   <= '{key: in_data.entry_key, payload: in_data.entry_payload};
      pos    <= count[ADDR_W-1:0];
    end
    if (cmd.take_root) begin
      head <= rd_a;
      if (sts.is_remove) begin
        hold <= rd_b;
        pos  <= '0;
      end
    end
    unique case (cmd.pos_sel)
      POS_PARENT: pos <= parent;
      POS_LEFT:   pos <= left[ADDR_W-1:0];
      POS_RIGHT:  pos <= right[ADDR_W-1:0];
      default:    ;
    endcase
    if (cmd.emit) begin
      out_data <= '{status: status, head_key: head.key, head_payload: head.payload,
                    entry_count: count};
    end
  end

endmodule

`default_nettype wire
